/* rtl/core/tod_pkg.sv */
// Shared types and constants for the torus outside distance block.
// No dependencies.
`timescale 1ns / 1ps
package tod_pkg;
  localparam int CoordW = 32;
  localparam int RadW = 31;
  localparam int SqW = 64;
  localparam int RootW = 32;
  localparam int QDepth = 4;
  localparam int QPtrW = 2;
  localparam int QCntW = 3;
  localparam logic [QCntW-1:0] QBusyLevel = 3'd2;
  localparam logic RegInner = 1'b0;
  localparam logic RegOuter = 1'b1;

  typedef struct packed {
    logic [SqW-1:0]    sq_x;
    logic [SqW-1:0]    sq_y;
    logic [CoordW-1:0] mag_z;
  } tod_item_t;

  function automatic logic [CoordW-1:0] mag(input logic [CoordW-1:0] v);
    mag = v[CoordW-1] ? (~v + 1'b1) : v;
  endfunction
endpackage

/* rtl/core/tod_front.sv */
// Front end: accepts a request, takes coordinate magnitudes and squares.
// Depends on tod_pkg.
`timescale 1ns / 1ps
module tod_front import tod_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [CoordW-1:0] pos_x,
  input  logic [CoordW-1:0] pos_y,
  input  logic [CoordW-1:0] pos_z,
  output logic              push,
  output tod_item_t         item
);
  logic              m_vld;
  logic [CoordW-1:0] mx, my, mz;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
      push  <= 1'b0;
    end else begin
      m_vld <= take;
      push  <= m_vld;
    end
    mx <= mag(pos_x);
    my <= mag(pos_y);
    mz <= mag(pos_z);
    item.sq_x  <= mx * mx;
    item.sq_y  <= my * my;
    item.mag_z <= mz;
  end
endmodule

/* rtl/core/tod_queue.sv */
// Short request queue between front and back; drains every cycle.
// Depends on tod_pkg.
`timescale 1ns / 1ps
module tod_queue import tod_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tod_item_t din,
  output logic      full,
  output logic      dvld,
  output tod_item_t dout
);
  tod_item_t        mem [QDepth];
  logic [QPtrW-1:0] wp, rp;
  logic [QCntW-1:0] cnt;
  logic             pop;

  assign pop  = (cnt != '0);
  assign full = (cnt >= QBusyLevel);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      cnt  <= '0;
      dvld <= 1'b0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt  <= cnt + QCntW'(push) - QCntW'(pop);
      dvld <= pop;
    end
    if (push) mem[wp] <= din;
    dout <= mem[rp];
  end
endmodule

/* rtl/core/tod_sqrt.sv */
// Pipelined integer square root, one root bit per stage, with a carried tag.
// Depends on tod_pkg.
`timescale 1ns / 1ps
module tod_sqrt import tod_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [SqW-1:0]    in_val,
  input  logic [CoordW-1:0] in_tag,
  output logic              out_vld,
  output logic [RootW-1:0]  out_root,
  output logic [CoordW-1:0] out_tag
);
  logic              vld  [RootW+1];
  logic [SqW-1:0]    val  [RootW+1];
  logic [RootW:0]    rem  [RootW+1];
  logic [RootW-1:0]  root [RootW+1];
  logic [CoordW-1:0] tag  [RootW+1];

  assign vld[0]  = in_vld;
  assign val[0]  = in_val;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign tag[0]  = in_tag;

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RootW+2:0] cat, trial;
    assign cat   = {rem[k], val[k][SqW-1 -: 2]};
    assign trial = {1'b0, root[k], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else     vld[k+1] <= vld[k];
      val[k+1] <= val[k] << 2;
      tag[k+1] <= tag[k];
      if (cat >= trial) begin
        rem[k+1]  <= (RootW+1)'(cat - trial);
        root[k+1] <= {root[k][RootW-2:0], 1'b1};
      end else begin
        rem[k+1]  <= cat[RootW:0];
        root[k+1] <= {root[k][RootW-2:0], 1'b0};
      end
    end
  end

  assign out_vld  = vld[RootW];
  assign out_root = root[RootW];
  assign out_tag  = tag[RootW];
endmodule

/* rtl/core/tod_back.sv */
// Back end: axis and middle circle distances, neck subtract or add.
// Depends on tod_pkg and tod_sqrt.
`timescale 1ns / 1ps
module tod_back import tod_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  tod_item_t         item,
  input  logic [RadW-1:0]   inner,
  input  logic [RadW-1:0]   outer,
  output logic              done,
  output logic [RootW-1:0]  outside_distance
);
  logic              s_vld, a_vld, h_vld, q_vld, t_vld, d_vld;
  logic [SqW-1:0]    s_sum, t_sum;
  logic [CoordW-1:0] s_z, a_z, h_z, d_tag;
  logic [RootW-1:0]  a_root, h_dist, d_root;
  logic [SqW-1:0]    q_h, q_z;
  logic [RootW-1:0]  mid, neck;
  logic              neck_neg;
  logic [RootW:0]    sum_res;

  assign mid      = RootW'(({1'b0, inner} + {1'b0, outer}) >> 1);
  assign neck_neg = outer < inner;
  assign neck     = neck_neg ? RootW'(({1'b0, inner} - {1'b0, outer} + 1'b1) >> 1)
                             : RootW'(({1'b0, outer} - {1'b0, inner}) >> 1);
  assign sum_res  = {1'b0, d_root} + {1'b0, neck};

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
      h_vld <= 1'b0;
      q_vld <= 1'b0;
      t_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      s_vld <= in_vld;
      h_vld <= a_vld;
      q_vld <= h_vld;
      t_vld <= q_vld;
      done  <= d_vld;
    end
    s_sum  <= item.sq_x + item.sq_y;
    s_z    <= item.mag_z;
    h_dist <= (a_root >= mid) ? a_root - mid : mid - a_root;
    h_z    <= a_z;
    q_h    <= h_dist * h_dist;
    q_z    <= h_z * h_z;
    t_sum  <= q_h + q_z;
    if (neck_neg)
      outside_distance <= sum_res[RootW] ? '1 : sum_res[RootW-1:0];
    else if (d_root > neck)
      outside_distance <= d_root - neck;
    else
      outside_distance <= '0;
  end

  tod_sqrt u_axis (
    .clk(clk), .rst(rst), .in_vld(s_vld), .in_val(s_sum), .in_tag(s_z),
    .out_vld(a_vld), .out_root(a_root), .out_tag(a_z)
  );

  tod_sqrt u_ring (
    .clk(clk), .rst(rst), .in_vld(t_vld), .in_val(t_sum), .in_tag('0),
    .out_vld(d_vld), .out_root(d_root), .out_tag(d_tag)
  );
endmodule

/* rtl/core/torus_outside_distance.sv */
// Top level of the torus outside distance block: register port and pipeline.
// Depends on tod_pkg, tod_front, tod_queue and tod_back.
`timescale 1ns / 1ps
// One point per cycle is taken while busy is low; each result appears on
// outside_distance with done for one cycle, in request order. The two
// square root pipelines have 32 stages each. The receiver cannot stall, so
// busy stays low in normal running.
module torus_outside_distance import tod_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  output logic        done,
  output logic [31:0] outside_distance,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [RadW-1:0] inner_radius, outer_radius;
  logic            push, qvld;
  tod_item_t       fitem, qitem;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegOuter) ? {1'b0, outer_radius} : {1'b0, inner_radius};

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_radius <= '0;
      outer_radius <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegInner) inner_radius <= pwdata[RadW-1:0];
      else                      outer_radius <= pwdata[RadW-1:0];
    end
  end

  tod_front u_front (
    .clk(clk), .rst(rst), .take(start && !busy),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .push(push), .item(fitem)
  );

  tod_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(fitem),
    .full(busy), .dvld(qvld), .dout(qitem)
  );

  tod_back u_back (
    .clk(clk), .rst(rst), .in_vld(qvld), .item(qitem),
    .inner(inner_radius), .outer(outer_radius),
    .done(done), .outside_distance(outside_distance)
  );
endmodule

/* rtl/core/tod_checker.sv */
// Port-level checks for the torus outside distance block, bound to the top.
// Depends on torus_outside_distance.
`timescale 1ns / 1ps
module tod_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);
  a_rst_quiet: assert property (@(posedge clk) $past(rst) |-> !busy && !done)
    else $error("busy or done after reset");
  a_ready: assert property (@(posedge clk) pready)
    else $error("pready low");
  a_wr_rd: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> (paddr != $past(paddr)) || (prdata[30:0] == $past(pwdata[30:0])))
    else $error("register readback mismatch");
  a_top_bit: assert property (@(posedge clk) !prdata[31])
    else $error("register top bit set");
endmodule

bind torus_outside_distance tod_checker u_tod_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .psel(psel), .penable(penable),
  .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
);
